// ===== hw/rtl/ird_pkg.sv =====
// Shared types and constants for the integer-to-radix-digits block.
// No dependencies; imported by ird_ctrl, ird_datapath and integer_to_radix_digits.
package ird_pkg;

    localparam int STEP_BITS     = 8;   // dividend bits retired per divide cycle
    localparam int DIGIT_W       = 4;   // one digit of a radix up to 16
    localparam int RADIX_W       = 5;
    localparam int CHAR_W        = 8;
    localparam int ALPHA_W       = 64;
    localparam int ALPHABET_SIZE = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CHAR_W-1:0]  MINUS_CHAR       = 8'h2D;
    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h6665646362613938;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RADIX      = 2'd0,
        CFG_ALPHA_LOW  = 2'd1,
        CFG_ALPHA_HIGH = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_SHOW
    } state_t;

    typedef struct packed {
        logic start;       // capture input value
        logic div_step;    // run one divide cycle
        logic emit_init;   // point read index at most significant digit
        logic mem_read;    // read digit store into read register
        logic load_sign;   // load minus sign into output register
        logic load_digit;  // load alphabet character into output register
        logic idx_dec;     // step read index toward least significant digit
    } cmd_t;

    typedef struct packed {
        logic digit_start; // divider at first cycle of a digit
        logic mag_zero;
        logic cnt_zero;
        logic cnt_full;
        logic negative;
        logic idx_zero;
        logic out_free;    // output register can take a beat this cycle
    } status_t;

endpackage

// ===== hw/rtl/ird_ctrl.sv =====
// Controller state machine for the integer-to-radix-digits block.
// Depends on ird_pkg; drives ird_datapath through cmd_t, watches status_t.
module ird_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ird_pkg::status_t   status,
    output ird_pkg::cmd_t      cmd
);
    import ird_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                // finish once the quotient is gone or the store is full
                if (status.digit_start &&
                    ((status.mag_zero && !status.cnt_zero) || status.cnt_full))
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = status.negative ? ST_SIGN : ST_READ;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.load_sign = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (status.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    if (status.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ird_datapath.sv =====
// Datapath: config registers, digit-serial divider, digit store and output register.
// Depends on ird_pkg; commanded by ird_ctrl.
module ird_datapath #(
    parameter int MAX_RADIX  = 16,
    parameter int MAX_DIGITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ird_pkg::cmd_t                      cmd,
    output ird_pkg::status_t                   status,
    input  logic signed [VALUE_BITS-1:0]       value,
    input  logic                               cfg_write,
    input  ird_pkg::cfg_index_t                cfg_index,
    input  logic [ird_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ird_pkg::CHAR_W-1:0]         character,
    output logic                               last
);
    import ird_pkg::*;

    localparam int STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W     = STEPS * STEP_BITS;
    localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W    = $clog2(MAX_DIGITS);
    localparam int RADIX_CAP = (MAX_RADIX < ALPHABET_SIZE) ? MAX_RADIX : ALPHABET_SIZE;

    logic [RADIX_W-1:0]    radix_reg;
    logic [ALPHA_W-1:0]    alpha_low_reg;
    logic [ALPHA_W-1:0]    alpha_high_reg;
    logic [DIV_W-1:0]      mag_reg;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [ADDR_W-1:0]     idx_reg;
    logic                  neg_reg;
    logic [DIGIT_W-1:0]    rd_data_reg;
    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;
    logic [DIGIT_W-1:0]    digit_store [MAX_DIGITS];

    logic [RADIX_W-1:0]    radix_eff;
    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] magnitude;
    logic [DIGIT_W-1:0]    rem_next;
    logic [STEP_BITS-1:0]  quot_bits;
    logic                  step_last;
    logic [2*ALPHA_W-1:0]  alphabet;
    logic [CHAR_W-1:0]     digit_char;

    // clamp radix into 2 .. min(MAX_RADIX, 16)
    always_comb
    begin
        radix_eff = radix_reg;
        if (radix_eff < RADIX_W'(2))
        begin
            radix_eff = RADIX_W'(2);
        end
        if (radix_eff > RADIX_W'(RADIX_CAP))
        begin
            radix_eff = RADIX_W'(RADIX_CAP);
        end
    end

    assign value_u   = value;
    assign magnitude = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
    assign step_last = (step_reg == STEP_W'(STEPS - 1));

    // one divide cycle: STEP_BITS restoring steps on a narrow remainder
    always_comb
    begin
        logic [DIGIT_W-1:0]   r;
        logic [DIGIT_W:0]     t;
        logic [STEP_BITS-1:0] chunk;
        r     = (step_reg == '0) ? '0 : rem_reg;
        chunk = mag_reg[DIV_W-1 -: STEP_BITS];
        quot_bits = '0;
        for (int k = STEP_BITS - 1; k >= 0; k--)
        begin
            t = {r, chunk[k]};
            if (t >= radix_eff)
            begin
                t            = t - radix_eff;
                quot_bits[k] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_RESET;
            alpha_low_reg  <= ALPHA_LOW_RESET;
            alpha_high_reg <= ALPHA_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RADIX:      radix_reg      <= cfg_data[RADIX_W-1:0];
                CFG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                CFG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg  <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                mag_reg  <= DIV_W'(magnitude);
                neg_reg  <= value_u[VALUE_BITS-1];
                cnt_reg  <= '0;
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                mag_reg <= (mag_reg << STEP_BITS) | DIV_W'(quot_bits);
                rem_reg <= rem_next;
                if (step_last)
                begin
                    step_reg <= '0;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
            if (cmd.emit_init)
            begin
                idx_reg <= ADDR_W'(cnt_reg - CNT_W'(1));
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - ADDR_W'(1);
            end
        end
    end

    // digit store, least significant digit at address 0
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && step_last)
        begin
            digit_store[cnt_reg[ADDR_W-1:0]] <= rem_next;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= digit_store[idx_reg];
        end
    end

    assign alphabet   = {alpha_high_reg, alpha_low_reg};
    assign digit_char = alphabet[{rd_data_reg, 3'b000} +: CHAR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_sign || cmd.load_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sign)
        begin
            char_reg <= MINUS_CHAR;
            last_reg <= 1'b0;
        end
        else if (cmd.load_digit)
        begin
            char_reg <= digit_char;
            last_reg <= (idx_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    assign status.digit_start = (step_reg == '0);
    assign status.mag_zero    = (mag_reg == '0);
    assign status.cnt_zero    = (cnt_reg == '0);
    assign status.cnt_full    = (cnt_reg == CNT_W'(MAX_DIGITS));
    assign status.negative    = neg_reg;
    assign status.idx_zero    = (idx_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

`ifndef SYNTHESIS
    a_no_step_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !status.cnt_full)
        else $error("divide step with digit store full");

    a_load_only_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_sign || cmd.load_digit) |-> status.out_free)
        else $error("output register overwritten while holding a beat");

    a_read_within_count : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_read |-> (!status.cnt_zero && (CNT_W'(idx_reg) < cnt_reg)))
        else $error("digit store read beyond written digits");
`endif

endmodule

// ===== hw/rtl/integer_to_radix_digits.sv =====
// Top level of the integer-to-radix-digits block.
// Depends on ird_pkg; instantiates ird_ctrl and ird_datapath.
//
// Use:
//   Input channel (in_valid/in_ready/value) takes one signed integer per beat.
//   Output channel (out_valid/out_ready/character/last) gives its text, most
//   significant digit first, one character per beat; a negative number opens
//   with a minus sign. last marks the final character of each number.
//   Config port: cfg_write with cfg_index/cfg_data writes radix, low alphabet
//   word or high alphabet word; write only while the block is idle.
// Divider and emit sequence:
//   Each digit is computed in the divider, which retires eight dividend bits
//   per cycle; a final step closes the division. Each character then takes a
//   digit store read and an output load, the sign an output load only.
//   One number at a time.
//   The next number is accepted as soon as the final character sits in the
//   output register.
// Reset clears the controller and output valid and restores radix 10 and the
// alphabet "0123456789abcdef". A stalled receiver holds the output register
// and freezes the emit sequence; nothing is dropped.
module integer_to_radix_digits #(
    parameter int MAX_RADIX  = 16,
    parameter int MAX_DIGITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [VALUE_BITS-1:0]       value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ird_pkg::CHAR_W-1:0]         character,
    output logic                               last,
    input  logic                               cfg_write,
    input  ird_pkg::cfg_index_t                cfg_index,
    input  logic [ird_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ird_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: accept, divide digit by digit, then emit sign and digits
    ird_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // registers, divider, digit store and output beat register
    ird_datapath #(
        .MAX_RADIX  (MAX_RADIX),
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule
